[rtl/hsl_pkg.sv]
// Shared types and constants of the HSL to RGB converter.
// No dependencies; the other files that use it refer to it by scoped names.

package hsl_pkg;

   // Width and largest value of one colour channel of a result.
   localparam int unsigned   COLOR_W  = 8;
   localparam logic [7:0]    CHAN_MAX = 8'hFF;

   // Register stages from the request port to the result register.
   localparam int unsigned   NUM_STAGES = 5;

   // Channel positions in the per-channel arrays.
   localparam int unsigned   CH_RED   = 0;
   localparam int unsigned   CH_GREEN = 1;
   localparam int unsigned   CH_BLUE  = 2;
   localparam int unsigned   NUM_CH   = 3;

   // Load enables of the stages held inside each channel unit.
   typedef struct packed {
      logic mul;
      logic sum;
      logic sat;
   } hsl_adv_type;

endpackage

[rtl/hsl_req_if.sv]
// Request channel of the HSL to RGB converter: valid/ready plus one colour.
// Depends on nothing; FRAC_BITS sets the width of the three fractions.

interface hsl_req_if #(
   parameter int FRAC_BITS = 16
);
   logic                 valid;
   logic                 ready;
   logic [FRAC_BITS:0]   hue;
   logic [FRAC_BITS:0]   saturation;
   logic [FRAC_BITS:0]   lightness;

   modport source (output valid, output hue, output saturation, output lightness,
                   input ready);
   modport sink   (input valid, input hue, input saturation, input lightness,
                   output ready);
endinterface

[rtl/hsl_rsp_if.sv]
// Result channel of the HSL to RGB converter: valid/ready plus 8-bit RGB.
// Depends on hsl_pkg for the channel width.

interface hsl_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [hsl_pkg::COLOR_W-1:0]   red;
   logic [hsl_pkg::COLOR_W-1:0]   green;
   logic [hsl_pkg::COLOR_W-1:0]   blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

[rtl/hsl_to_rgb.sv]
// Top level of the HSL to RGB converter: five-stage pipeline with valid bits.
// Depends on hsl_pkg, hsl_req_if, hsl_rsp_if, hsl_ramp and hsl_chan.
//
//   channel   direction   payload                          handshake
//   req_ch    in          hue, saturation, lightness       valid / ready
//   rsp_ch    out         red, green, blue (8 bits each)   valid / ready
//
// One request enters per clock unless a stall at rsp_ch has filled the pipeline;
// each result passes through the five register stages (ramp and offset, saturation
// product, gain product, sum, scale and clamp). Reset clears only the valid
// bits. A stall at rsp_ch holds the stages behind it, while empty stages keep
// filling, so requests are accepted until the whole pipeline is full.

module hsl_to_rgb #(
   parameter int FRAC_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   hsl_req_if.sink      req_ch,
   hsl_rsp_if.source    rsp_ch
);
   localparam int FW = FRAC_BITS + 1;
   localparam int MW = FRAC_BITS + 2;
   localparam int GW = FRAC_BITS + 2;
   localparam int EW = 2 * FRAC_BITS + 3;
   localparam int NS = hsl_pkg::NUM_STAGES;

   localparam logic signed [MW-1:0] ONE_M = MW'(2 ** FRAC_BITS);

   logic [NS-1:0]          v_in;
   logic [NS-1:0]          v_ff;
   logic [NS:0]            rdy;
   hsl_pkg::hsl_adv_type   adv;

   logic [FW-1:0]          s1_ff;
   logic [FW-1:0]          l1_ff;
   logic signed [MW-1:0]   m1_in;
   logic signed [MW-1:0]   m1_ff;
   logic signed [GW-1:0]   g_in  [hsl_pkg::NUM_CH];
   logic signed [GW-1:0]   g1_ff [hsl_pkg::NUM_CH];

   logic signed [EW-1:0]   e2_in;
   logic signed [EW-1:0]   e2_ff;
   logic [FW-1:0]          l2_ff;
   logic signed [GW-1:0]   g2_ff [hsl_pkg::NUM_CH];

   logic [FW-1:0]          l3_ff;

   // A stage may load when it is empty or when the stage after it moves on.
   always_comb begin
      rdy[NS] = rsp_ch.ready;
      for (int i = NS - 1; i >= 0; i--) begin
         rdy[i] = ~v_ff[i] | rdy[i+1];
      end
      if (rdy[0]) begin
         v_in[0] = req_ch.valid;
      end else begin
         v_in[0] = v_ff[0];
      end
      for (int i = 1; i < NS; i++) begin
         if (rdy[i]) begin
            v_in[i] = v_ff[i-1];
         end else begin
            v_in[i] = v_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   assign adv.mul = rdy[2];
   assign adv.sum = rdy[3];
   assign adv.sat = rdy[4];

   // q - l equals s*l below one half and s*(1-l) above; this m is the second
   // factor. With zero saturation the spread vanishes and the result is grey.
   assign m1_in = (req_ch.lightness[FRAC_BITS:FRAC_BITS-1] == 2'b00)
                  ? $signed({1'b0, req_ch.lightness})
                  : ONE_M - $signed({1'b0, req_ch.lightness});

   hsl_ramp #(.FRAC_BITS(FRAC_BITS), .HUE_SHIFT(1)) u_ramp_red (
      .hue  (req_ch.hue),
      .gain (g_in[hsl_pkg::CH_RED])
   );

   hsl_ramp #(.FRAC_BITS(FRAC_BITS), .HUE_SHIFT(0)) u_ramp_green (
      .hue  (req_ch.hue),
      .gain (g_in[hsl_pkg::CH_GREEN])
   );

   hsl_ramp #(.FRAC_BITS(FRAC_BITS), .HUE_SHIFT(-1)) u_ramp_blue (
      .hue  (req_ch.hue),
      .gain (g_in[hsl_pkg::CH_BLUE])
   );

   assign e2_in = EW'($signed({1'b0, s1_ff})) * EW'(m1_ff);

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         s1_ff <= req_ch.saturation;
         l1_ff <= req_ch.lightness;
         m1_ff <= m1_in;
         g1_ff <= g_in;
      end
      if (rdy[1]) begin
         e2_ff <= e2_in;
         l2_ff <= l1_ff;
         g2_ff <= g1_ff;
      end
      if (rdy[2]) begin
         l3_ff <= l2_ff;
      end
   end

   hsl_chan #(.FRAC_BITS(FRAC_BITS)) u_chan_red (
      .clock  (clock),
      .adv    (adv),
      .spread (e2_ff),
      .gain   (g2_ff[hsl_pkg::CH_RED]),
      .light  (l3_ff),
      .color  (rsp_ch.red)
   );

   hsl_chan #(.FRAC_BITS(FRAC_BITS)) u_chan_green (
      .clock  (clock),
      .adv    (adv),
      .spread (e2_ff),
      .gain   (g2_ff[hsl_pkg::CH_GREEN]),
      .light  (l3_ff),
      .color  (rsp_ch.green)
   );

   hsl_chan #(.FRAC_BITS(FRAC_BITS)) u_chan_blue (
      .clock  (clock),
      .adv    (adv),
      .spread (e2_ff),
      .gain   (g2_ff[hsl_pkg::CH_BLUE]),
      .light  (l3_ff),
      .color  (rsp_ch.blue)
   );

   assign req_ch.ready = rdy[0];
   assign rsp_ch.valid = v_ff[NS-1];

endmodule

[rtl/hsl_ramp.sv]
// Piecewise hue ramp of one channel, returned as the gain 2w-1 in fixed point.
// Combinational; no package dependencies.

module hsl_ramp #(
   parameter int FRAC_BITS = 16,
   parameter int HUE_SHIFT = 0
) (
   input  logic [FRAC_BITS:0]          hue,
   output logic signed [FRAC_BITS+1:0] gain
);
   localparam int TW = FRAC_BITS + 4;
   localparam int GW = FRAC_BITS + 2;

   // The ramp argument is kept in units of a third of one LSB, so the
   // segment bounds at 1/6, 1/2 and 2/3 are exact integers.
   localparam logic signed [TW-1:0] ONE   = TW'(2 ** FRAC_BITS);
   localparam logic signed [TW-1:0] FULL  = TW'(3 * (2 ** FRAC_BITS));
   localparam logic signed [TW-1:0] HALF  = TW'(2 ** (FRAC_BITS - 1));
   localparam logic signed [TW-1:0] MID   = TW'(3 * (2 ** (FRAC_BITS - 1)));
   localparam logic signed [TW-1:0] TWO   = TW'(2 ** (FRAC_BITS + 1));
   localparam logic signed [TW-1:0] SHIFT = TW'(HUE_SHIFT * (2 ** FRAC_BITS));

   logic signed [TW-1:0] t_raw;
   logic signed [TW-1:0] t_lo;
   logic signed [TW-1:0] t_wr;

   assign t_raw = $signed({3'b000, hue}) + $signed({2'b00, hue, 1'b0}) + SHIFT;
   assign t_lo  = (t_raw < 0) ? t_raw + FULL : t_raw;
   assign t_wr  = (t_lo > FULL) ? t_lo - FULL : t_lo;

   always_comb begin
      if (t_wr < HALF) begin
         gain = GW'((t_wr <<< 2) - ONE);
      end else if (t_wr < MID) begin
         gain = GW'(ONE);
      end else if (t_wr < TWO) begin
         gain = GW'(((TWO - t_wr) <<< 2) - ONE);
      end else begin
         gain = GW'(-ONE);
      end
   end

endmodule

[rtl/hsl_chan.sv]
// Back end of one colour channel: product, offset, then scale by 255 and clamp.
// Depends on hsl_pkg for the stage enables and the channel width.

module hsl_chan #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                clock,
   input  hsl_pkg::hsl_adv_type                adv,
   input  logic signed [2*FRAC_BITS+2:0]       spread,
   input  logic signed [FRAC_BITS+1:0]         gain,
   input  logic [FRAC_BITS:0]                  light,
   output logic [hsl_pkg::COLOR_W-1:0]         color
);
   localparam int PW = 3 * FRAC_BITS + 3;
   localparam int XW = 3 * FRAC_BITS + 4;
   localparam int SW = 3 * FRAC_BITS + 8;

   logic signed [PW-1:0]           prod_in;
   logic signed [PW-1:0]           prod_ff;
   logic signed [XW-1:0]           x_in;
   logic signed [XW-1:0]           x_ff;
   logic [SW-1:0]                  scaled;
   logic [hsl_pkg::COLOR_W-1:0]    color_in;
   logic [hsl_pkg::COLOR_W-1:0]    color_ff;

   // Both operands are signed, so they are sign-extended to the product width.
   assign prod_in = PW'(spread) * PW'(gain);

   // Channel value times 2^(3F): lightness plus spread times gain.
   assign x_in = $signed({3'b000, light, {(2 * FRAC_BITS){1'b0}}}) + XW'(prod_ff);

   // 255x as 256x - x on the in-range fraction; the integer part is the result.
   assign scaled = {x_ff[3*FRAC_BITS-1:0], 8'h00} - {8'h00, x_ff[3*FRAC_BITS-1:0]};

   always_comb begin
      if (x_ff[XW-1]) begin
         color_in = '0;
      end else if (|x_ff[XW-2:3*FRAC_BITS]) begin
         color_in = hsl_pkg::CHAN_MAX;
      end else begin
         color_in = scaled[SW-1:3*FRAC_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (adv.mul) begin
         prod_ff <= prod_in;
      end
      if (adv.sum) begin
         x_ff <= x_in;
      end
      if (adv.sat) begin
         color_ff <= color_in;
      end
   end

   assign color = color_ff;

endmodule

[dv/hsl_to_rgb_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench of hsl_to_rgb: directed and random colours go in
// through hsl_req_if, results come back through hsl_rsp_if and are checked.
// Depends on hsl_pkg, hsl_req_if, hsl_rsp_if and the hsl_to_rgb RTL.

module hsl_to_rgb_tb;

   localparam int     FRAC_BITS      = 16;
   localparam longint FX_ONE         = longint'(1) << FRAC_BITS;
   localparam int     CLK_PERIOD     = 10;
   localparam int     RESET_CYCLES   = 10;
   localparam int     RANDOM_COLOURS = 730;
   localparam int     WATCHDOG_LIMIT = 500;

   typedef logic [FRAC_BITS:0] frac_type;

   typedef struct packed {
      frac_type hue;
      frac_type saturation;
      frac_type lightness;
   } hsl_colour_type;

   typedef struct packed {
      logic [hsl_pkg::COLOR_W-1:0] red;
      logic [hsl_pkg::COLOR_W-1:0] green;
      logic [hsl_pkg::COLOR_W-1:0] blue;
   } rgb_colour_type;

   logic clock;
   logic reset;

   hsl_req_if #(.FRAC_BITS(FRAC_BITS)) req_ch ();
   hsl_rsp_if                          rsp_ch ();

   hsl_to_rgb #(.FRAC_BITS(FRAC_BITS)) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   hsl_colour_type pending_colours[$];
   rgb_colour_type expected_rgb[$];
   int          error_count = 0;
   logic        req_taken   = 1'b0;
   logic        quiet_phase = 1'b0;
   int unsigned cycle_count = 0;
   int unsigned stuck_cycles = 0;
   int unsigned req_gap  = 0;
   int unsigned rsp_stall = 0;

   // ---------------------------------------------------------------- prediction

   // Hue ramp weight; t is in units of 1/(3 << FRAC_BITS) of a turn.
   function automatic longint hue_ramp(longint t);
      longint full_turn;
      full_turn = 3 * FX_ONE;
      if (t < 0)
         t += full_turn;
      if (t > full_turn)
         t -= full_turn;
      if (t < FX_ONE / 2)
         return 2 * t;
      if (t < full_turn / 2)
         return FX_ONE;
      if (t < 2 * FX_ONE)
         return 2 * (2 * FX_ONE - t);
      return 0;
   endfunction

   // floor(255 * (p + d*w)), clamped; p and d carry 2*FRAC_BITS fraction bits.
   function automatic logic [7:0] scale_channel(longint p, longint d, longint w);
      longint d_hi, d_lo, coarse, fine, level;
      d_hi   = d >>> FRAC_BITS;
      d_lo   = d - d_hi * FX_ONE;
      coarse = 255 * p + 255 * d_hi * w;
      fine   = 255 * d_lo * w;
      level  = (coarse + (fine >>> FRAC_BITS)) >>> (2 * FRAC_BITS);
      if (level < 0)
         return 8'd0;
      if (level > 255)
         return hsl_pkg::CHAN_MAX;
      return level[7:0];
   endfunction

   function automatic rgb_colour_type hsl_convert(hsl_colour_type c);
      longint         h, s, l, q, p, d;
      rgb_colour_type rgb;
      h = longint'(c.hue);
      s = longint'(c.saturation);
      l = longint'(c.lightness);
      if (s == 0) begin
         rgb.red   = scale_channel(l * FX_ONE, 0, 0);
         rgb.green = rgb.red;
         rgb.blue  = rgb.red;
         return rgb;
      end
      if (l < FX_ONE / 2)
         q = l * (FX_ONE + s);
      else
         q = l * FX_ONE + s * FX_ONE - l * s;
      p = 2 * l * FX_ONE - q;
      d = q - p;
      rgb.red   = scale_channel(p, d, hue_ramp(3 * h + FX_ONE));
      rgb.green = scale_channel(p, d, hue_ramp(3 * h));
      rgb.blue  = scale_channel(p, d, hue_ramp(3 * h - FX_ONE));
      return rgb;
   endfunction

   // ------------------------------------------------------------------ stimulus

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (quiet_phase || r < 60)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Values on and around the points where the arithmetic changes course.
   function automatic frac_type edge_value();
      frac_type edges[14] = '{17'd0, 17'd1, 17'd10922, 17'd10923, 17'd21845, 17'd21846,
                              17'd32767, 17'd32768, 17'd32769, 17'd43691, 17'd54613,
                              17'd65535, 17'd65536, 17'h1FFFF};
      return edges[$urandom_range(0, 13)];
   endfunction

   function automatic hsl_colour_type random_colour();
      hsl_colour_type c;
      case ($urandom_range(0, 9))
         0: begin
            c.hue        = frac_type'($urandom);
            c.saturation = frac_type'($urandom);
            c.lightness  = frac_type'($urandom);
         end
         1: begin
            c.hue        = frac_type'($urandom);
            c.saturation = '0;
            c.lightness  = frac_type'($urandom_range(0, 65536));
         end
         2, 3: begin
            c.hue        = edge_value();
            c.saturation = edge_value();
            c.lightness  = edge_value();
         end
         default: begin
            c.hue        = frac_type'($urandom_range(0, 65536));
            c.saturation = frac_type'($urandom_range(0, 65536));
            c.lightness  = frac_type'($urandom_range(0, 65536));
         end
      endcase
      return c;
   endfunction

   task automatic add_colour(frac_type hue, frac_type saturation, frac_type lightness);
      pending_colours.push_back('{hue: hue, saturation: saturation, lightness: lightness});
   endtask

   task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         error_count++;
      end
   endtask

   // ------------------------------------------------------------- clock, reset

   initial clock = 1'b0;
   always #(CLK_PERIOD / 2) clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count % 256 == 0)
         quiet_phase <= ($urandom_range(0, 3) == 0);
   end

   // ------------------------------------------------------------------- driver

   // A new request is presented once the previous one has been taken.
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_taken) begin
         if (req_gap > 0) begin
            req_gap--;
            req_ch.valid <= 1'b0;
         end else if (pending_colours.size() > 0) begin
            hsl_colour_type c;
            c = pending_colours.pop_front();
            req_ch.valid      <= 1'b1;
            req_ch.hue        <= c.hue;
            req_ch.saturation <= c.saturation;
            req_ch.lightness  <= c.lightness;
            req_gap = pick_gap();
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
         rsp_stall = pick_gap();
      end
   end

   // ------------------------------------------------------------------ monitor

   always @(posedge clock) begin
      rgb_colour_type want;
      req_taken <= !reset && req_ch.valid && req_ch.ready;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready)
            expected_rgb.push_back(hsl_convert('{hue: req_ch.hue,
                                                 saturation: req_ch.saturation,
                                                 lightness: req_ch.lightness}));
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_rgb.size() == 0) begin
               $error("result with no request outstanding: rgb %0d %0d %0d",
                      rsp_ch.red, rsp_ch.green, rsp_ch.blue);
               error_count++;
            end else begin
               want = expected_rgb.pop_front();
               check_field("red", want.red, rsp_ch.red);
               check_field("green", want.green, rsp_ch.green);
               check_field("blue", want.blue, rsp_ch.blue);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         stuck_cycles <= 0;
      else
         stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // ----------------------------------------------------------------- sequence

   initial begin
      reset = 1'b1;

      // Grey, including lightness above one which must clamp to full scale.
      add_colour(17'd0, 17'd0, 17'd0);
      add_colour(17'd0, 17'd0, 17'd65536);
      add_colour(17'd12345, 17'd0, 17'd32768);
      add_colour(17'h1FFFF, 17'd0, 17'h1FFFF);
      // Fully saturated colours around the hue wheel, at the ramp corners.
      add_colour(17'd0, 17'd65536, 17'd32768);
      add_colour(17'd10923, 17'd65536, 17'd32768);
      add_colour(17'd21845, 17'd65536, 17'd32768);
      add_colour(17'd32768, 17'd65536, 17'd32768);
      add_colour(17'd43691, 17'd65536, 17'd32768);
      add_colour(17'd54613, 17'd65536, 17'd32768);
      add_colour(17'd65536, 17'd65536, 17'd32768);
      // Lightness either side of one half selects the other form of q.
      add_colour(17'd5000, 17'd40000, 17'd32767);
      add_colour(17'd5000, 17'd40000, 17'd32768);
      // Hue beyond one full turn, so the ramp argument wraps.
      add_colour(17'd80000, 17'd65536, 17'd30000);
      add_colour(17'h1FFFF, 17'd30000, 17'd50000);
      // Field extremes and inputs above one.
      add_colour(17'h1FFFF, 17'h1FFFF, 17'h1FFFF);
      add_colour(17'd1, 17'd1, 17'd1);
      add_colour(17'd30000, 17'h1FFFF, 17'd0);
      add_colour(17'd30000, 17'h1FFFF, 17'd20000);
      add_colour(17'd30000, 17'd65536, 17'd65536);
      add_colour(17'd70000, 17'd90000, 17'd98304);

      for (int i = 0; i < RANDOM_COLOURS; i++)
         pending_colours.push_back(random_colour());

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_colours.size() > 0 || req_ch.valid || expected_rgb.size() > 0)
         @(posedge clock);
      repeat (4 * hsl_pkg::NUM_STAGES) @(posedge clock);

      if (error_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

[files.f]
rtl/hsl_pkg.sv
rtl/hsl_req_if.sv
rtl/hsl_rsp_if.sv
rtl/hsl_ramp.sv
rtl/hsl_chan.sv
rtl/hsl_to_rgb.sv
dv/hsl_to_rgb_tb.sv
